@@ sv/slm_pkg.sv @@
// shared constants, types and codes of the stereo level meter
package slm_pkg;

   localparam int CHANNEL_COUNT = 2;
   localparam int COEF_BITS     = 16;
   localparam int SAMPLE_W      = 16;
   localparam int LEVEL_W       = 16;
   localparam int GAIN_W        = 16;
   localparam int GAIN_FRAC     = 8;
   localparam int MS_W          = 31;

   // square root: one result bit per iteration, two iterations per cycle
   localparam int ROOT_ITERS     = (MS_W + 1) / 2;
   localparam int ITERS_PER_STEP = 2;
   localparam int ROOT_STEPS     = ROOT_ITERS / ITERS_PER_STEP;
   localparam int STEP_CNT_W     = $clog2(ROOT_STEPS);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(32768);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RMS_ATTACK  = 3'd0,
      CSR_RMS_DECAY   = 3'd1,
      CSR_PEAK_ATTACK = 3'd2,
      CSR_PEAK_DECAY  = 3'd3,
      CSR_RMS_GAIN    = 3'd4,
      CSR_PEAK_GAIN   = 3'd5,
      CSR_MONO        = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_MAG,
      CMD_PROD,
      CMD_MS_PROD,
      CMD_MS_UPD,
      CMD_ROOT_LOAD,
      CMD_ROOT_STEP,
      CMD_GAIN,
      CMD_REPORT,
      CMD_DECAY_PROD,
      CMD_DECAY_UPD
   } lane_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAG,
      ST_PROD,
      ST_MS_PROD,
      ST_MS_UPD,
      ST_ROOT_LOAD,
      ST_ROOT_STEP,
      ST_GAIN,
      ST_REPORT,
      ST_DECAY_PROD,
      ST_DECAY_UPD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] rms_attack;
      logic [COEF_BITS-1:0] rms_decay;
      logic [COEF_BITS-1:0] peak_attack;
      logic [COEF_BITS-1:0] peak_decay;
      logic [GAIN_W-1:0]    rms_gain;
      logic [GAIN_W-1:0]    peak_gain;
   } lane_cfg_type;

endpackage

@@ sv/slm_isqrt.sv @@
// iterative integer square root of a mean-square envelope, two bits per cycle while step is high
module slm_isqrt (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        step,
   input  logic [slm_pkg::MS_W-1:0]    operand,
   output logic [slm_pkg::LEVEL_W-1:0] root
);

   localparam int ROOT_W = slm_pkg::MS_W + 1;
   localparam logic [slm_pkg::MS_W-1:0] BIT_TOP =
      slm_pkg::MS_W'(1) << (2 * (slm_pkg::ROOT_ITERS - 1));

   logic [slm_pkg::MS_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0]        acc_ff, acc_in;
   logic [slm_pkg::MS_W-1:0] bit_ff, bit_in;

   always_comb begin
      logic [ROOT_W-1:0] trial;
      rem_in = rem_ff;
      acc_in = acc_ff;
      bit_in = bit_ff;
      trial  = '0;
      if (load) begin
         rem_in = operand;
         acc_in = '0;
         bit_in = BIT_TOP;
      end else if (step) begin
         for (int i = 0; i < slm_pkg::ITERS_PER_STEP; i++) begin
            trial = acc_in + ROOT_W'(bit_in);
            if (ROOT_W'(rem_in) >= trial) begin
               rem_in = rem_in - trial[slm_pkg::MS_W-1:0];
               acc_in = (acc_in >> 1) + ROOT_W'(bit_in);
            end else begin
               acc_in = acc_in >> 1;
            end
            bit_in = bit_in >> 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      bit_ff <= bit_in;
   end

   assign root = acc_ff[slm_pkg::LEVEL_W-1:0];

endmodule

@@ sv/slm_lane.sv @@
// one channel lane: mean-square and peak envelopes, level report
module slm_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  slm_pkg::lane_cmd_type        cmd,
   input  slm_pkg::lane_cfg_type        cfg,
   input  logic [slm_pkg::SAMPLE_W-1:0] sample,
   output logic [slm_pkg::LEVEL_W-1:0]  rms_level,
   output logic [slm_pkg::LEVEL_W-1:0]  peak_level
);

   localparam int PK_PROD_W = slm_pkg::COEF_BITS + slm_pkg::LEVEL_W;
   localparam int MS_PROD_W = slm_pkg::COEF_BITS + slm_pkg::MS_W;
   localparam int GPROD_W   = slm_pkg::LEVEL_W + slm_pkg::GAIN_W;
   localparam int SQ_W      = 2 * slm_pkg::SAMPLE_W;

   function automatic logic [slm_pkg::LEVEL_W-1:0] clamp_level(input logic [GPROD_W-1:0] p);
      logic [GPROD_W-slm_pkg::GAIN_FRAC-1:0] s;
      s = p[GPROD_W-1:slm_pkg::GAIN_FRAC];
      if (s > (GPROD_W-slm_pkg::GAIN_FRAC)'(slm_pkg::FULL_SCALE)) begin
         return slm_pkg::FULL_SCALE;
      end
      return s[slm_pkg::LEVEL_W-1:0];
   endfunction

   logic [slm_pkg::LEVEL_W-1:0] mag_ff, mag_in;
   logic [slm_pkg::MS_W-1:0]    sq_ff, sq_in;
   logic                        pk_up_ff, pk_up_in;
   logic                        ms_up_ff, ms_up_in;
   logic [PK_PROD_W-1:0]        pk_prod_ff, pk_prod_in;
   logic [MS_PROD_W-1:0]        ms_prod_ff, ms_prod_in;
   logic [GPROD_W-1:0]          pk_gprod_ff, pk_gprod_in;
   logic [GPROD_W-1:0]          rms_gprod_ff, rms_gprod_in;
   logic [slm_pkg::LEVEL_W-1:0] pk_env_ff, pk_env_in;
   logic [slm_pkg::MS_W-1:0]    ms_env_ff, ms_env_in;
   logic [slm_pkg::LEVEL_W-1:0] rms_lvl_ff, rms_lvl_in;
   logic [slm_pkg::LEVEL_W-1:0] rpt_peak_ff, rpt_peak_in;

   logic [slm_pkg::LEVEL_W-1:0] root;
   logic [SQ_W-1:0]             sq_full;
   logic                        pk_up, ms_up;
   logic [slm_pkg::LEVEL_W-1:0] pk_diff, pk_step;
   logic [slm_pkg::MS_W-1:0]    ms_diff, ms_step;
   logic [slm_pkg::COEF_BITS-1:0] pk_k, ms_k;

   slm_isqrt u_isqrt (
      .clock   (clock),
      .load    (cmd == slm_pkg::CMD_ROOT_LOAD),
      .step    (cmd == slm_pkg::CMD_ROOT_STEP),
      .operand (ms_env_ff),
      .root    (root)
   );

   // follow step: land k times the old distance away from the input
   assign sq_full = mag_ff * mag_ff;
   assign pk_up   = mag_ff >= pk_env_ff;
   assign pk_diff = pk_up ? (mag_ff - pk_env_ff) : (pk_env_ff - mag_ff);
   assign pk_k    = pk_up ? cfg.peak_attack : cfg.peak_decay;
   assign ms_up   = sq_ff >= ms_env_ff;
   assign ms_diff = ms_up ? (sq_ff - ms_env_ff) : (ms_env_ff - sq_ff);
   assign ms_k    = ms_up ? cfg.rms_attack : cfg.rms_decay;
   assign pk_step = pk_prod_ff[slm_pkg::COEF_BITS +: slm_pkg::LEVEL_W];
   assign ms_step = ms_prod_ff[slm_pkg::COEF_BITS +: slm_pkg::MS_W];

   always_comb begin
      mag_in       = mag_ff;
      sq_in        = sq_ff;
      pk_up_in     = pk_up_ff;
      ms_up_in     = ms_up_ff;
      pk_prod_in   = pk_prod_ff;
      ms_prod_in   = ms_prod_ff;
      pk_gprod_in  = pk_gprod_ff;
      rms_gprod_in = rms_gprod_ff;
      pk_env_in    = pk_env_ff;
      ms_env_in    = ms_env_ff;
      rms_lvl_in   = rms_lvl_ff;
      rpt_peak_in  = rpt_peak_ff;
      case (cmd)
         slm_pkg::CMD_MAG: begin
            // two's complement magnitude, full-scale negative gives 32768
            mag_in = sample[slm_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
         end
         slm_pkg::CMD_PROD: begin
            sq_in      = sq_full[slm_pkg::MS_W-1:0];
            pk_up_in   = pk_up;
            pk_prod_in = pk_k * pk_diff;
         end
         slm_pkg::CMD_MS_PROD: begin
            ms_up_in   = ms_up;
            ms_prod_in = ms_k * ms_diff;
            pk_env_in  = pk_up_ff ? (mag_ff - pk_step) : (mag_ff + pk_step);
         end
         slm_pkg::CMD_MS_UPD: begin
            ms_env_in = ms_up_ff ? (sq_ff - ms_step) : (sq_ff + ms_step);
         end
         slm_pkg::CMD_ROOT_LOAD: begin
            pk_gprod_in = pk_env_ff * cfg.peak_gain;
         end
         slm_pkg::CMD_GAIN: begin
            rms_gprod_in = root * cfg.rms_gain;
         end
         slm_pkg::CMD_REPORT: begin
            rms_lvl_in  = clamp_level(rms_gprod_ff);
            rpt_peak_in = clamp_level(pk_gprod_ff);
         end
         slm_pkg::CMD_DECAY_PROD: begin
            ms_prod_in = cfg.rms_decay * ms_env_ff;
            pk_prod_in = cfg.peak_decay * pk_env_ff;
         end
         slm_pkg::CMD_DECAY_UPD: begin
            ms_env_in = ms_step;
            pk_env_in = pk_step;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pk_env_ff   <= '0;
         ms_env_ff   <= '0;
         rpt_peak_ff <= '0;
      end else begin
         pk_env_ff   <= pk_env_in;
         ms_env_ff   <= ms_env_in;
         rpt_peak_ff <= rpt_peak_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      sq_ff        <= sq_in;
      pk_up_ff     <= pk_up_in;
      ms_up_ff     <= ms_up_in;
      pk_prod_ff   <= pk_prod_in;
      ms_prod_ff   <= ms_prod_in;
      pk_gprod_ff  <= pk_gprod_in;
      rms_gprod_ff <= rms_gprod_in;
      rms_lvl_ff   <= rms_lvl_in;
   end

   assign rms_level  = rms_lvl_ff;
   assign peak_level = rpt_peak_ff;

endmodule

@@ sv/stereo_rms_peak_level_meter.sv @@
// top level of the stereo rms and peak level meter
//
// Takes one request per stereo frame (or silent-packet event) and keeps a
// mean-square and a peak envelope per channel, each following its input with
// the attack coefficient on a rise and the decay coefficient otherwise. The
// two channels run in identical lanes side by side under one sequencer, and a
// merging output register combines their levels into one response. A frame
// that is not last of a packet causes no response, and the next request is
// taken once its envelope updates are done. A last frame adds the square
// root, gain and report steps and gives one response with rms =
// isqrt(envelope) * rms_gain and peak = envelope * peak_gain (Q8.8 gains),
// each saturated to 32768 (1.0). Each lane's square root unit resolves two
// result bits per cycle. A silent-packet event scales both envelopes once by
// their decay coefficients, and the response carries rms zero and the last
// reported peak. The final step waits only while an earlier response is
// still held and stalled in the output register. Coefficients are Q0.16, so
// 65535 is just below 1.0. In mono mode the right lane sees the left sample.
// Registers are to be written through the csr port only while the meter is
// idle, which the block does not enforce; indexes beyond the list are ignored.
module stereo_rms_peak_level_meter (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic signed [slm_pkg::SAMPLE_W-1:0] req_left_sample,
   input  logic signed [slm_pkg::SAMPLE_W-1:0] req_right_sample,
   input  logic                           req_last_of_packet,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [slm_pkg::LEVEL_W-1:0]    rsp_rms_left,
   output logic [slm_pkg::LEVEL_W-1:0]    rsp_rms_right,
   output logic [slm_pkg::LEVEL_W-1:0]    rsp_peak_left,
   output logic [slm_pkg::LEVEL_W-1:0]    rsp_peak_right,
   // register write port
   input  logic                           csr_write,
   input  logic [slm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CH = slm_pkg::CHANNEL_COUNT;

   // configuration registers
   slm_pkg::lane_cfg_type cfg_ff, cfg_in;
   logic                  mono_ff, mono_in;

   // sequencer
   slm_pkg::state_type                state_ff, state_in;
   logic [slm_pkg::STEP_CNT_W-1:0]    cnt_ff, cnt_in;
   slm_pkg::lane_cmd_type             cmd;

   // captured request
   logic                              kind_ff, kind_in;
   logic                              last_ff, last_in;
   logic [slm_pkg::SAMPLE_W-1:0]      smp_ff [CH];
   logic [slm_pkg::SAMPLE_W-1:0]      smp_in [CH];

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [slm_pkg::LEVEL_W-1:0]       rsp_rms_ff  [CH];
   logic [slm_pkg::LEVEL_W-1:0]       rsp_rms_in  [CH];
   logic [slm_pkg::LEVEL_W-1:0]       rsp_peak_ff [CH];
   logic [slm_pkg::LEVEL_W-1:0]       rsp_peak_in [CH];

   logic [slm_pkg::LEVEL_W-1:0]       lane_rms  [CH];
   logic [slm_pkg::LEVEL_W-1:0]       lane_peak [CH];

   logic accept;
   logic out_free;
   logic rsp_load;

   assign req_stall = (state_ff != slm_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == slm_pkg::ST_OUT) && out_free;

   // register writes
   always_comb begin
      cfg_in  = cfg_ff;
      mono_in = mono_ff;
      if (csr_write) begin
         case (csr_index)
            slm_pkg::CSR_RMS_ATTACK:  cfg_in.rms_attack  = csr_wdata;
            slm_pkg::CSR_RMS_DECAY:   cfg_in.rms_decay   = csr_wdata;
            slm_pkg::CSR_PEAK_ATTACK: cfg_in.peak_attack = csr_wdata;
            slm_pkg::CSR_PEAK_DECAY:  cfg_in.peak_decay  = csr_wdata;
            slm_pkg::CSR_RMS_GAIN:    cfg_in.rms_gain    = csr_wdata;
            slm_pkg::CSR_PEAK_GAIN:   cfg_in.peak_gain   = csr_wdata;
            slm_pkg::CSR_MONO:        mono_in            = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // request capture, mono copies the left sample into the right lane
   always_comb begin
      kind_in = kind_ff;
      last_in = last_ff;
      smp_in  = smp_ff;
      if (accept) begin
         kind_in   = req_kind;
         last_in   = req_last_of_packet;
         smp_in[0] = req_left_sample;
         smp_in[1] = mono_ff ? req_left_sample : req_right_sample;
      end
   end

   // sequencer: next state and lane command
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = slm_pkg::CMD_NONE;
      case (state_ff)
         slm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_kind ? slm_pkg::ST_DECAY_PROD : slm_pkg::ST_MAG;
            end
         end
         slm_pkg::ST_MAG: begin
            cmd      = slm_pkg::CMD_MAG;
            state_in = slm_pkg::ST_PROD;
         end
         slm_pkg::ST_PROD: begin
            cmd      = slm_pkg::CMD_PROD;
            state_in = slm_pkg::ST_MS_PROD;
         end
         slm_pkg::ST_MS_PROD: begin
            cmd      = slm_pkg::CMD_MS_PROD;
            state_in = slm_pkg::ST_MS_UPD;
         end
         slm_pkg::ST_MS_UPD: begin
            cmd      = slm_pkg::CMD_MS_UPD;
            state_in = last_ff ? slm_pkg::ST_ROOT_LOAD : slm_pkg::ST_IDLE;
         end
         slm_pkg::ST_ROOT_LOAD: begin
            cmd      = slm_pkg::CMD_ROOT_LOAD;
            cnt_in   = '0;
            state_in = slm_pkg::ST_ROOT_STEP;
         end
         slm_pkg::ST_ROOT_STEP: begin
            cmd    = slm_pkg::CMD_ROOT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == slm_pkg::STEP_CNT_W'(slm_pkg::ROOT_STEPS - 1)) begin
               state_in = slm_pkg::ST_GAIN;
            end
         end
         slm_pkg::ST_GAIN: begin
            cmd      = slm_pkg::CMD_GAIN;
            state_in = slm_pkg::ST_REPORT;
         end
         slm_pkg::ST_REPORT: begin
            cmd      = slm_pkg::CMD_REPORT;
            state_in = slm_pkg::ST_OUT;
         end
         slm_pkg::ST_DECAY_PROD: begin
            cmd      = slm_pkg::CMD_DECAY_PROD;
            state_in = slm_pkg::ST_DECAY_UPD;
         end
         slm_pkg::ST_DECAY_UPD: begin
            cmd      = slm_pkg::CMD_DECAY_UPD;
            state_in = slm_pkg::ST_OUT;
         end
         slm_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = slm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slm_pkg::ST_IDLE;
         end
      endcase
   end

   // channel lanes
   for (genvar c = 0; c < CH; c++) begin : g_lane
      slm_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .cfg        (cfg_ff),
         .sample     (smp_ff[c]),
         .rms_level  (lane_rms[c]),
         .peak_level (lane_peak[c])
      );
   end

   // merge lane levels into the response, silent events report rms zero
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rms_in   = rsp_rms_ff;
      rsp_peak_in  = rsp_peak_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         for (int c = 0; c < CH; c++) begin
            rsp_rms_in[c]  = kind_ff ? '0 : lane_rms[c];
            rsp_peak_in[c] = lane_peak[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= slm_pkg::ST_IDLE;
         cnt_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
         mono_ff            <= 1'b0;
         cfg_ff.rms_attack  <= '0;
         cfg_ff.rms_decay   <= '0;
         cfg_ff.peak_attack <= '0;
         cfg_ff.peak_decay  <= '0;
         cfg_ff.rms_gain    <= slm_pkg::GAIN_W'(256);
         cfg_ff.peak_gain   <= slm_pkg::GAIN_W'(256);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         mono_ff      <= mono_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      smp_ff      <= smp_in;
      rsp_rms_ff  <= rsp_rms_in;
      rsp_peak_ff <= rsp_peak_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rms_left   = rsp_rms_ff[0];
   assign rsp_rms_right  = rsp_rms_ff[1];
   assign rsp_peak_left  = rsp_peak_ff[0];
   assign rsp_peak_right = rsp_peak_ff[1];

endmodule

@@ sv/slm_checker.sv @@
// port-level checks of the level meter and their binding to the top level
module slm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [slm_pkg::LEVEL_W-1:0]    rsp_rms_left,
   input logic [slm_pkg::LEVEL_W-1:0]    rsp_rms_right,
   input logic [slm_pkg::LEVEL_W-1:0]    rsp_peak_left,
   input logic [slm_pkg::LEVEL_W-1:0]    rsp_peak_right
);

   // a held response keeps its valid and its levels
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_rms_left, rsp_rms_right, rsp_peak_left, rsp_peak_right}))
      else $error("stalled response changed");

   // one request at a time: busy right after an accepted request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request channel open right after a request");

   // no response can be produced straight after a request is accepted
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("response appeared too early");

   // all levels saturate at full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rms_left <= slm_pkg::FULL_SCALE &&
         rsp_rms_right <= slm_pkg::FULL_SCALE &&
         rsp_peak_left <= slm_pkg::FULL_SCALE &&
         rsp_peak_right <= slm_pkg::FULL_SCALE)
      else $error("level above full scale");

endmodule

bind stereo_rms_peak_level_meter slm_checker u_slm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_rms_left   (rsp_rms_left),
   .rsp_rms_right  (rsp_rms_right),
   .rsp_peak_left  (rsp_peak_left),
   .rsp_peak_right (rsp_peak_right)
);

@@ test/tb_top.sv @@
// self-checking testbench for the stereo rms and peak level meter
`timescale 1ns / 100ps

module tb_top;

   localparam int  HALF_PERIOD    = 6;
   localparam int  RESET_CYCLES   = 11;
   // leave room beyond the time a last frame or a plain frame needs
   localparam int  SETTLE_CYCLES  = 40;
   localparam int  RANDOM_ITEMS   = 950;
   localparam int  RANDOM_PHASES  = 8;
   localparam int  MAX_REPORTED   = 10;
   localparam int  TIMEOUT_NS     = 10_000_000;
   localparam int  COEF_FULL      = 65535;
   localparam int  GAIN_UNITY     = 256;

   localparam int  SAMPLE_W      = slm_pkg::SAMPLE_W;
   localparam int  LEVEL_W       = slm_pkg::LEVEL_W;
   localparam int  COEF_BITS     = slm_pkg::COEF_BITS;
   localparam int  GAIN_W        = slm_pkg::GAIN_W;
   localparam int  MS_W          = slm_pkg::MS_W;
   localparam int  CHANNEL_COUNT = slm_pkg::CHANNEL_COUNT;
   localparam int  CSR_IDX_W     = slm_pkg::CSR_IDX_W;
   localparam int  CSR_DATA_W    = slm_pkg::CSR_DATA_W;

   // request kinds
   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_SILENT = 1'b1;

   // index past the register list, must be ignored by the meter
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic                       kind;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       last_of_packet;
   } meter_request_type;

   typedef struct {
      logic [LEVEL_W-1:0] rms_left;
      logic [LEVEL_W-1:0] rms_right;
      logic [LEVEL_W-1:0] peak_left;
      logic [LEVEL_W-1:0] peak_right;
   } level_report_type;

   // dut signals, inputs known from time zero
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_kind = 1'b0;
   logic signed [SAMPLE_W-1:0] req_left_sample = '0;
   logic signed [SAMPLE_W-1:0] req_right_sample = '0;
   logic                       req_last_of_packet = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]         rsp_rms_left;
   logic [LEVEL_W-1:0]         rsp_rms_right;
   logic [LEVEL_W-1:0]         rsp_peak_left;
   logic [LEVEL_W-1:0]         rsp_peak_right;
   logic                       csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // shadow copy of the register file, at reset values
   logic [COEF_BITS-1:0] rms_attack_k  = '0;
   logic [COEF_BITS-1:0] rms_decay_k   = '0;
   logic [COEF_BITS-1:0] peak_attack_k = '0;
   logic [COEF_BITS-1:0] peak_decay_k  = '0;
   logic [GAIN_W-1:0]    rms_gain_q    = GAIN_W'(GAIN_UNITY);
   logic [GAIN_W-1:0]    peak_gain_q   = GAIN_W'(GAIN_UNITY);
   logic                 mono_on       = 1'b0;

   // predicted envelopes per channel, zero after reset
   logic [MS_W-1:0]    ms_env[CHANNEL_COUNT]    = '{default: '0};
   logic [LEVEL_W-1:0] pk_env[CHANNEL_COUNT]    = '{default: '0};
   logic [LEVEL_W-1:0] last_peak[CHANNEL_COUNT] = '{default: '0};

   meter_request_type pending_requests[$];
   level_report_type  expected_levels[$];
   meter_request_type in_flight;

   int  requests_queued = 0;
   int  requests_taken  = 0;
   int  level_errors    = 0;
   int  send_gap        = 0;
   int  stall_hold      = 0;
   bit  idling_on       = 1'b1;
   int  phase;

   stereo_rms_peak_level_meter i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_last_of_packet (req_last_of_packet),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rms_left       (rsp_rms_left),
      .rsp_rms_right      (rsp_rms_right),
      .rsp_peak_left      (rsp_peak_left),
      .rsp_peak_right     (rsp_peak_right),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------
   // level predictor
   // ---------------------------------------------------------------

   // envelope moves toward x: decay factor when x is below, attack otherwise
   function automatic logic [63:0] track(input logic [63:0] env, input logic [63:0] x,
                                         input logic [63:0] k_rise,
                                         input logic [63:0] k_fall);
      if (x < env)
         return x + ((k_fall * (env - x)) >> COEF_BITS);
      return x - ((k_rise * (x - env)) >> COEF_BITS);
   endfunction

   // floor square root, one result bit at a time from the top
   function automatic logic [63:0] root_of(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int i = 15; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   // q8.8 gain then saturate to full scale
   function automatic logic [LEVEL_W-1:0] scale_level(input logic [63:0] level,
                                                      input logic [63:0] gain);
      logic [63:0] scaled;
      scaled = (level * gain) >> slm_pkg::GAIN_FRAC;
      if (scaled > 64'(slm_pkg::FULL_SCALE))
         return slm_pkg::FULL_SCALE;
      return scaled[LEVEL_W-1:0];
   endfunction

   // advance the envelopes by one request and queue any level report
   function automatic void update_meter(input meter_request_type r);
      logic [SAMPLE_W-1:0] raw[CHANNEL_COUNT];
      logic [63:0]         mag;
      logic [LEVEL_W-1:0]  rms_lvl[CHANNEL_COUNT];
      logic [LEVEL_W-1:0]  peak_lvl[CHANNEL_COUNT];
      level_report_type    rep;
      if (r.kind == KIND_SILENT) begin
         // silent packet: decay once, rms zero, repeat last peak
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            ms_env[c] = MS_W'((64'(ms_env[c]) * 64'(rms_decay_k)) >> COEF_BITS);
            pk_env[c] = LEVEL_W'((64'(pk_env[c]) * 64'(peak_decay_k)) >> COEF_BITS);
         end
         rep.rms_left   = '0;
         rep.rms_right  = '0;
         rep.peak_left  = last_peak[0];
         rep.peak_right = last_peak[1];
         expected_levels.push_back(rep);
      end else begin
         raw[0] = r.left_sample;
         raw[1] = mono_on ? r.left_sample : r.right_sample;
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            mag = raw[c][SAMPLE_W-1] ? (64'h10000 - 64'(raw[c])) : 64'(raw[c]);
            ms_env[c] = MS_W'(track(64'(ms_env[c]), mag * mag, 64'(rms_attack_k),
                                    64'(rms_decay_k)));
            pk_env[c] = LEVEL_W'(track(64'(pk_env[c]), mag, 64'(peak_attack_k),
                                       64'(peak_decay_k)));
         end
         if (r.last_of_packet) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
               rms_lvl[c]   = scale_level(root_of(64'(ms_env[c])), 64'(rms_gain_q));
               peak_lvl[c]  = scale_level(64'(pk_env[c]), 64'(peak_gain_q));
               last_peak[c] = peak_lvl[c];
            end
            rep.rms_left   = rms_lvl[0];
            rep.rms_right  = rms_lvl[1];
            rep.peak_left  = peak_lvl[0];
            rep.peak_right = peak_lvl[1];
            expected_levels.push_back(rep);
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idling_on || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
         3, 4: return SAMPLE_W'($urandom_range(0, 511)) - 16'd256;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [COEF_BITS-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return COEF_BITS'(COEF_FULL);
         2, 3: return COEF_BITS'($urandom_range(56000, COEF_FULL));
         default: return COEF_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return '1;
         2, 3: return GAIN_W'(GAIN_UNITY);
         4, 5: return GAIN_W'($urandom_range(1, 1024));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   task automatic push_item(input logic kind, input logic [SAMPLE_W-1:0] left,
                            input logic [SAMPLE_W-1:0] right, input logic last);
      meter_request_type r;
      r.kind           = kind;
      r.left_sample    = left;
      r.right_sample   = right;
      r.last_of_packet = last;
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   // one register write, strobe dropped on the following edge
   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         slm_pkg::CSR_RMS_ATTACK:  rms_attack_k  = value;
         slm_pkg::CSR_RMS_DECAY:   rms_decay_k   = value;
         slm_pkg::CSR_PEAK_ATTACK: peak_attack_k = value;
         slm_pkg::CSR_PEAK_DECAY:  peak_decay_k  = value;
         slm_pkg::CSR_RMS_GAIN:    rms_gain_q    = value;
         slm_pkg::CSR_PEAK_GAIN:   peak_gain_q   = value;
         slm_pkg::CSR_MONO:        mono_on       = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_settings(input logic [COEF_BITS-1:0] ra, input logic [COEF_BITS-1:0] rd,
                                input logic [COEF_BITS-1:0] pa, input logic [COEF_BITS-1:0] pd,
                                input logic [GAIN_W-1:0] rg, input logic [GAIN_W-1:0] pg,
                                input logic mono);
      set_register(slm_pkg::CSR_RMS_ATTACK, ra);
      set_register(slm_pkg::CSR_RMS_DECAY, rd);
      set_register(slm_pkg::CSR_PEAK_ATTACK, pa);
      set_register(slm_pkg::CSR_PEAK_DECAY, pd);
      set_register(slm_pkg::CSR_RMS_GAIN, rg);
      set_register(slm_pkg::CSR_PEAK_GAIN, pg);
      // upper data bits are don't-care for the mono flag
      set_register(slm_pkg::CSR_MONO,
                   (CSR_DATA_W'($urandom) & 16'hFFFE) | CSR_DATA_W'(mono));
      // write to the unused index must leave everything alone
      set_register(CSR_UNUSED, CSR_DATA_W'($urandom));
   endtask

   // sender holds off until every request is in and every report is out
   task automatic wait_for_idle();
      while (requests_taken != requests_queued || expected_levels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly whole packets of random length, some silent events and stray frames
   task automatic queue_random_traffic(input int budget);
      int made;
      int roll;
      int plen;
      made = 0;
      while (made < budget) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            push_item(KIND_SILENT, pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
            made++;
         end else if (roll < 13) begin
            push_item(KIND_FRAME, pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
            made++;
         end else begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            for (int i = 0; i < plen; i++)
               push_item(KIND_FRAME, pick_sample(), pick_sample(), i == plen - 1);
            made += plen;
         end
      end
   endtask

   task automatic check_level(input string field, input logic [LEVEL_W-1:0] want,
                              input logic [LEVEL_W-1:0] got);
      if (want !== got) begin
         level_errors++;
         if (level_errors <= MAX_REPORTED)
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, field, want, got);
      end
   endtask

   // ---------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // request taken this edge, advance the prediction
         if (req_valid && !req_stall) begin
            update_meter(in_flight);
            requests_taken++;
         end
         if (req_valid && req_stall) begin
            // stalled request holds its payload
         end else if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            in_flight = pending_requests.pop_front();
            req_valid          <= 1'b1;
            req_kind           <= in_flight.kind;
            req_left_sample    <= in_flight.left_sample;
            req_right_sample   <= in_flight.right_sample;
            req_last_of_packet <= in_flight.last_of_packet;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // response monitor with random back-pressure
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      level_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               level_errors++;
               if (level_errors <= MAX_REPORTED)
                  $display("%0t: unexpected response rms %0d/%0d peak %0d/%0d", $realtime,
                           rsp_rms_left, rsp_rms_right, rsp_peak_left, rsp_peak_right);
            end else begin
               want = expected_levels.pop_front();
               check_level("rms_left", want.rms_left, rsp_rms_left);
               check_level("rms_right", want.rms_right, rsp_rms_right);
               check_level("peak_left", want.peak_left, rsp_peak_left);
               check_level("peak_right", want.peak_right, rsp_peak_right);
            end
         end
         if (stall_hold != 0) begin
            rsp_stall <= 1'b1;
            stall_hold--;
         end else begin
            rsp_stall <= 1'b0;
            stall_hold = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero coefficients so envelopes track the input exactly
      push_item(KIND_SILENT, 16'h1234, 16'hFEDC, 1'b1);
      push_item(KIND_FRAME, 16'h8000, 16'h7FFF, 1'b1);
      push_item(KIND_FRAME, 16'h7FFF, 16'h8000, 1'b1);
      push_item(KIND_FRAME, 16'h0000, 16'h0000, 1'b1);
      push_item(KIND_FRAME, 16'hFFFF, 16'h0001, 1'b0);
      push_item(KIND_FRAME, 16'h0001, 16'hFFFF, 1'b1);
      push_item(KIND_SILENT, 16'h8000, 16'h7FFF, 1'b0);
      wait_for_idle();

      // coefficients and gains at maximum, mono source
      load_settings('1, '1, '1, '1, '1, '1, 1'b1);
      push_item(KIND_FRAME, 16'h8000, 16'd1234, 1'b1);
      push_item(KIND_FRAME, 16'd100, -16'sd200, 1'b0);
      push_item(KIND_FRAME, 16'd5, 16'h0000, 1'b1);
      push_item(KIND_SILENT, 16'h0000, 16'h0000, 1'b1);
      push_item(KIND_SILENT, 16'h7FFF, 16'h8000, 1'b0);
      push_item(KIND_FRAME, 16'h7FFF, 16'h8000, 1'b1);
      wait_for_idle();

      // mixed corners: half attack, tiny decay, rms gain zero
      load_settings(16'h8000, 16'h0001, '1, '0, '0, GAIN_W'(GAIN_UNITY), 1'b0);
      push_item(KIND_FRAME, 16'd20000, -16'sd20000, 1'b0);
      push_item(KIND_FRAME, -16'sd300, 16'd300, 1'b1);
      push_item(KIND_SILENT, 16'h5555, 16'hAAAA, 1'b1);
      push_item(KIND_FRAME, 16'h0000, 16'h0000, 1'b1);
      wait_for_idle();

      // random phases, each under fresh settings; every fourth without idling
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_settings(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                       pick_gain(), pick_gain(), 1'($urandom_range(0, 1)));
         idling_on = (phase % 4) != 3;
         queue_random_traffic(RANDOM_ITEMS / RANDOM_PHASES);
         wait_for_idle();
      end

      if (level_errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
sv/slm_pkg.sv
sv/slm_isqrt.sv
sv/slm_lane.sv
sv/stereo_rms_peak_level_meter.sv
sv/slm_checker.sv
test/tb_top.sv
